// File: sv/litp_pkg.sv
// Shared types and widths for the line inlier test and projection block.
// Holds word structs, register index codes and derived arithmetic widths.
// No dependencies.
`default_nettype none

package litp_pkg;

	localparam int COORD_W = 32;
	localparam int INDEX_W = 20;
	localparam int LIMIT_W = COORD_W - 1;
	localparam int CFG_IDX_W = 3;

	// derived widths of the datapath
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = 2 * COORD_W + 2;
	localparam int DOT_W = 2 * COORD_W + 3;
	localparam int CABS_W = 2 * COORD_W + 1;
	localparam int TABS_W = 2 * COORD_W + 2;
	localparam int TLO_W = COORD_W + 1;
	localparam int DSQ_W = 2 * COORD_W;
	localparam int DD_W = 2 * COORD_W + 2;
	localparam int DDH_W = COORD_W + 1;
	localparam int DEN_W = DD_W + 1;
	localparam int QUOT_W = COORD_W + 2;
	localparam int MAGN_W = COORD_W + TABS_W;
	localparam int NUM_W = MAGN_W + 2;
	localparam int HH_W = 2 * (CABS_W - COORD_W);
	localparam int HL_W = CABS_W;
	localparam int LL_W = 2 * COORD_W;
	localparam int DT_W = COORD_W + TLO_W;
	localparam int CSQ_W = 2 * CABS_W;
	localparam int CC_W = CSQ_W + 2;
	localparam int LIM2_W = 2 * LIMIT_W;
	localparam int PP_W = LIMIT_W + DDH_W;
	localparam int LIM2DD_W = LIM2_W + DD_W;
	localparam int SUM_W = QUOT_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_X   = 3'd0,
		CFG_A_Y   = 3'd1,
		CFG_A_Z   = 3'd2,
		CFG_B_X   = 3'd3,
		CFG_B_Y   = 3'd4,
		CFG_B_Z   = 3'd5,
		CFG_LIMIT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [INDEX_W-1:0]        point_index;
	} point_t;

	typedef struct packed {
		logic                      is_inlier;
		logic [INDEX_W-1:0]        index_out;
		logic signed [COORD_W-1:0] proj_x;
		logic signed [COORD_W-1:0] proj_y;
		logic signed [COORD_W-1:0] proj_z;
		logic                      line_degenerate;
	} result_t;

endpackage

`default_nettype wire

// File: sv/line_inlier_test_and_projection.sv
// Top level of the line inlier test and projection block.
// Depends on litp_pkg (types, widths, register codes).
//
// Usage:
//   Configuration: write line point A, line point B and the distance limit
//   through cfg_we / cfg_index / cfg_wdata (indexes 0..6), one register per
//   cycle, only while no word is in flight. A write is seen by every point
//   word accepted from the next cycle on. Unused indexes are dropped.
//   Point channel (pt_valid / pt_ready / pt_word): one 3D point and its index.
//   Result channel (res_valid / res_ready / res_word): one result per point,
//   in order: inlier flag, index echo, projection onto the line, degenerate.
//   Pipeline: a point word runs through 6 multiply and sum stages, a
//   reduction stage, one restoring-divider stage per quotient bit (34) and
//   a final round/saturate stage.
//   Throughput: one word per cycle while the pipe is not stalled, set by
//   the fully pipelined divider.
//   Stall: a one-word skid register behind the last stage catches the word
//   the receiver refuses; pt_ready then drops and the whole pipe holds until
//   the skid word is taken. Nothing is dropped or repeated.
//   Reset: config registers clear (line A = B = 0, degenerate), and all
//   valid bits and the skid flag clear at once; data registers do not.
`default_nettype none

module line_inlier_test_and_projection (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [litp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [litp_pkg::COORD_W-1:0]       cfg_wdata,
	input  logic                               pt_valid,
	output logic                               pt_ready,
	input  litp_pkg::point_t                   pt_word,
	output logic                               res_valid,
	input  logic                               res_ready,
	output litp_pkg::result_t                  res_word
);

	localparam int C = litp_pkg::COORD_W;
	localparam int IW = litp_pkg::INDEX_W;
	localparam int QW = litp_pkg::QUOT_W;
	localparam int NW = litp_pkg::NUM_W;

	// configuration registers
	logic signed [C-1:0]                 a_q [3];
	logic signed [C-1:0]                 b_q [3];
	logic [litp_pkg::LIMIT_W-1:0]        lim_q;

	// line-derived values, free running and registered level after level
	logic signed [litp_pkg::DIFF_W-1:0]  dvec1_q [3];
	logic                                degen1_q;
	logic [litp_pkg::LIM2_W-1:0]         lim2_1_q;
	logic [litp_pkg::DSQ_W-1:0]          dsq2_q [3];
	logic [C-1:0]                        dabs2_q [3];
	logic                                dneg2_q [3];
	logic [litp_pkg::LIM2_W-1:0]         lim2_2_q;
	logic [litp_pkg::DD_W-1:0]           dd3_q;
	logic [litp_pkg::LIM2_W-1:0]         lim2_3_q;
	logic [litp_pkg::PP_W-1:0]           pp4_q [4];
	logic [litp_pkg::LIM2DD_W-1:0]       lim2dd5_q;

	// point pipeline
	logic                                en;
	logic                                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_sf;
	logic [IW-1:0]                       idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic signed [C-1:0]                 pin [3];
	logic signed [litp_pkg::DIFF_W-1:0]  w_s1 [3];
	logic signed [litp_pkg::PROD_W-1:0]  crs_a_s2 [3];
	logic signed [litp_pkg::PROD_W-1:0]  crs_b_s2 [3];
	logic signed [litp_pkg::PROD_W-1:0]  dot_s2 [3];
	logic signed [litp_pkg::CROSS_W-1:0] c_s3 [3];
	logic signed [litp_pkg::DOT_W-1:0]   t_s3;
	logic [litp_pkg::CABS_W-1:0]         cabs_s4 [3];
	logic [litp_pkg::TABS_W-1:0]         tabs_s4;
	logic                                tneg_s4;
	logic [litp_pkg::HH_W-1:0]           hh_s5 [3];
	logic [litp_pkg::HL_W-1:0]           hl_s5 [3];
	logic [litp_pkg::LL_W-1:0]           ll_s5 [3];
	logic [litp_pkg::DT_W-1:0]           dth_s5 [3];
	logic [litp_pkg::DT_W-1:0]           dtl_s5 [3];
	logic                                nneg_s5 [3];
	logic [litp_pkg::CSQ_W-1:0]          csq_s6 [3];
	logic [litp_pkg::MAGN_W-1:0]         mag_s6 [3];
	logic                                nneg_s6 [3];
	logic [litp_pkg::CC_W-1:0]           cc_s7;

	// divider stages; index 0 is the stage that feeds the first quotient bit
	logic                                vld_sd [QW+1];
	logic [IW-1:0]                       idx_sd [QW+1];
	logic [NW-1:0]                       rem_sd [QW+1][3];
	logic [QW-1:0]                       quo_sd [QW+1][3];
	logic                                neg_sd [QW+1][3];
	logic                                inl_sd [1:QW];
	logic [NW-1:0]                       den_ext;
	logic [NW-1:0]                       shd [1:QW];
	logic                                ge_c [1:QW][3];
	logic [NW-1:0]                       rem_nx [1:QW][3];
	logic [QW-1:0]                       quo_nx [1:QW][3];

	// final stage and skid
	logic signed [litp_pkg::SUM_W-1:0]   off_c [3];
	logic signed [litp_pkg::SUM_W-1:0]   sum_c [3];
	logic signed [C-1:0]                 proj_c [3];
	litp_pkg::result_t                   res_nx;
	litp_pkg::result_t                   word_sf;
	litp_pkg::result_t                   skid_q;
	logic                                skid_v_q;

	// ---------------------------------------------------------------
	// Configuration write decode
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= '0;
				b_q[i] <= '0;
			end
			lim_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				litp_pkg::CFG_A_X:   a_q[0] <= cfg_wdata;
				litp_pkg::CFG_A_Y:   a_q[1] <= cfg_wdata;
				litp_pkg::CFG_A_Z:   a_q[2] <= cfg_wdata;
				litp_pkg::CFG_B_X:   b_q[0] <= cfg_wdata;
				litp_pkg::CFG_B_Y:   b_q[1] <= cfg_wdata;
				litp_pkg::CFG_B_Z:   b_q[2] <= cfg_wdata;
				litp_pkg::CFG_LIMIT: lim_q <= cfg_wdata[litp_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Line-derived values. They recompute every cycle; a point reaches
	// stage n no earlier than level n settles, so every stage reads
	// values that already match the current line.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				dvec1_q[i] <= '0;
				dsq2_q[i] <= '0;
				dabs2_q[i] <= '0;
				dneg2_q[i] <= 1'b0;
			end
			for (int k = 0; k < 4; k++) pp4_q[k] <= '0;
			degen1_q <= 1'b1;
			lim2_1_q <= '0;
			lim2_2_q <= '0;
			lim2_3_q <= '0;
			dd3_q <= '0;
			lim2dd5_q <= '0;
		end else begin
			for (int i = 0; i < 3; i++) begin
				dvec1_q[i] <= litp_pkg::DIFF_W'(b_q[i]) - litp_pkg::DIFF_W'(a_q[i]);
				dsq2_q[i] <= litp_pkg::DSQ_W'(dvec1_q[i] * dvec1_q[i]);
				dabs2_q[i] <= dvec1_q[i][litp_pkg::DIFF_W-1] ?
					C'(-dvec1_q[i]) : C'(dvec1_q[i]);
				dneg2_q[i] <= dvec1_q[i][litp_pkg::DIFF_W-1];
			end
			degen1_q <= (a_q[0] == b_q[0]) && (a_q[1] == b_q[1]) && (a_q[2] == b_q[2]);
			lim2_1_q <= lim_q * lim_q;
			lim2_2_q <= lim2_1_q;
			lim2_3_q <= lim2_2_q;
			dd3_q <= litp_pkg::DD_W'(dsq2_q[0]) + litp_pkg::DD_W'(dsq2_q[1])
				+ litp_pkg::DD_W'(dsq2_q[2]);
			// split limit^2 x |d|^2 into four narrow partial products
			pp4_q[0] <= lim2_3_q[litp_pkg::LIMIT_W-1:0] * dd3_q[litp_pkg::DDH_W-1:0];
			pp4_q[1] <= lim2_3_q[litp_pkg::LIMIT_W-1:0]
				* dd3_q[litp_pkg::DD_W-1:litp_pkg::DDH_W];
			pp4_q[2] <= lim2_3_q[litp_pkg::LIM2_W-1:litp_pkg::LIMIT_W]
				* dd3_q[litp_pkg::DDH_W-1:0];
			pp4_q[3] <= lim2_3_q[litp_pkg::LIM2_W-1:litp_pkg::LIMIT_W]
				* dd3_q[litp_pkg::DD_W-1:litp_pkg::DDH_W];
			lim2dd5_q <= litp_pkg::LIM2DD_W'(pp4_q[0])
				+ (litp_pkg::LIM2DD_W'(pp4_q[1]) << litp_pkg::DDH_W)
				+ (litp_pkg::LIM2DD_W'(pp4_q[2]) << litp_pkg::LIMIT_W)
				+ (litp_pkg::LIM2DD_W'(pp4_q[3]) << (litp_pkg::LIMIT_W + litp_pkg::DDH_W));
		end
	end

	// ---------------------------------------------------------------
	// Handshake: the pipe advances as a whole while the skid is empty.
	// ---------------------------------------------------------------
	assign en = !skid_v_q;
	assign pt_ready = en;
	assign res_valid = skid_v_q || v_sf;
	assign res_word = skid_v_q ? skid_q : word_sf;

	assign pin[0] = pt_word.point_x;
	assign pin[1] = pt_word.point_y;
	assign pin[2] = pt_word.point_z;

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_sf <= 1'b0;
			for (int j = 0; j <= QW; j++) vld_sd[j] <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= pt_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
				vld_sd[0] <= v_s6;
				for (int j = 1; j <= QW; j++) vld_sd[j] <= vld_sd[j-1];
				v_sf <= vld_sd[QW];
			end
			// catch a refused word, release it once taken
			if (skid_v_q) begin
				if (res_ready) skid_v_q <= 1'b0;
			end else if (v_sf && !res_ready) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && v_sf && !res_ready) skid_q <= word_sf;
	end

	// ---------------------------------------------------------------
	// Divider step: one quotient bit per stage, restoring form.
	// Quotient is round(|d_i * t| / |d|^2), taken as
	// floor((2|num| + dd) / (2 dd)).
	// ---------------------------------------------------------------
	assign den_ext = NW'({dd3_q, 1'b0});

	always_comb begin
		for (int j = 1; j <= QW; j++) begin
			shd[j] = den_ext << (QW - j);
			for (int i = 0; i < 3; i++) begin
				ge_c[j][i] = rem_sd[j-1][i] >= shd[j];
				rem_nx[j][i] = ge_c[j][i] ? rem_sd[j-1][i] - shd[j] : rem_sd[j-1][i];
				quo_nx[j][i] = quo_sd[j-1][i] | (QW'(ge_c[j][i]) << (QW - j));
			end
		end
	end

	// final stage: apply sign, add A, saturate, override a degenerate line
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_c[i] = neg_sd[QW][i] ? -$signed(litp_pkg::SUM_W'(quo_sd[QW][i]))
				: $signed(litp_pkg::SUM_W'(quo_sd[QW][i]));
			sum_c[i] = litp_pkg::SUM_W'(a_q[i]) + off_c[i];
			if ((&sum_c[i][litp_pkg::SUM_W-1:C-1]) || !(|sum_c[i][litp_pkg::SUM_W-1:C-1])) begin
				proj_c[i] = sum_c[i][C-1:0];
			end else if (sum_c[i][litp_pkg::SUM_W-1]) begin
				proj_c[i] = {1'b1, {(C-1){1'b0}}};
			end else begin
				proj_c[i] = {1'b0, {(C-1){1'b1}}};
			end
			if (degen1_q) proj_c[i] = a_q[i];
		end
		res_nx.is_inlier = inl_sd[QW] && !degen1_q;
		res_nx.index_out = idx_sd[QW];
		res_nx.proj_x = proj_c[0];
		res_nx.proj_y = proj_c[1];
		res_nx.proj_z = proj_c[2];
		res_nx.line_degenerate = degen1_q;
	end

	// ---------------------------------------------------------------
	// Datapath registers; hold everything while the pipe is stalled.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: w = P - A
			for (int i = 0; i < 3; i++) begin
				w_s1[i] <= litp_pkg::DIFF_W'(pin[i]) - litp_pkg::DIFF_W'(a_q[i]);
			end
			idx_s1 <= pt_word.point_index;

			// stage 2: cross and dot products of w with d
			crs_a_s2[0] <= w_s1[1] * dvec1_q[2];
			crs_b_s2[0] <= w_s1[2] * dvec1_q[1];
			crs_a_s2[1] <= w_s1[2] * dvec1_q[0];
			crs_b_s2[1] <= w_s1[0] * dvec1_q[2];
			crs_a_s2[2] <= w_s1[0] * dvec1_q[1];
			crs_b_s2[2] <= w_s1[1] * dvec1_q[0];
			for (int i = 0; i < 3; i++) dot_s2[i] <= w_s1[i] * dvec1_q[i];
			idx_s2 <= idx_s1;

			// stage 3: cross components and t = w.d
			for (int i = 0; i < 3; i++) c_s3[i] <= crs_a_s2[i] - crs_b_s2[i];
			t_s3 <= litp_pkg::DOT_W'(dot_s2[0]) + litp_pkg::DOT_W'(dot_s2[1])
				+ litp_pkg::DOT_W'(dot_s2[2]);
			idx_s3 <= idx_s2;

			// stage 4: magnitudes
			for (int i = 0; i < 3; i++) begin
				cabs_s4[i] <= c_s3[i][litp_pkg::CROSS_W-1] ?
					litp_pkg::CABS_W'(-c_s3[i]) : litp_pkg::CABS_W'(c_s3[i]);
			end
			tabs_s4 <= t_s3[litp_pkg::DOT_W-1] ?
				litp_pkg::TABS_W'(-t_s3) : litp_pkg::TABS_W'(t_s3);
			tneg_s4 <= t_s3[litp_pkg::DOT_W-1];
			idx_s4 <= idx_s3;

			// stage 5: partial products of |c|^2 and |d_i * t|
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= cabs_s4[i][litp_pkg::CABS_W-1:C] * cabs_s4[i][litp_pkg::CABS_W-1:C];
				hl_s5[i] <= cabs_s4[i][litp_pkg::CABS_W-1:C] * cabs_s4[i][C-1:0];
				ll_s5[i] <= cabs_s4[i][C-1:0] * cabs_s4[i][C-1:0];
				dth_s5[i] <= dabs2_q[i] * tabs_s4[litp_pkg::TABS_W-1:litp_pkg::TLO_W];
				dtl_s5[i] <= dabs2_q[i] * tabs_s4[litp_pkg::TLO_W-1:0];
				nneg_s5[i] <= dneg2_q[i] ^ tneg_s4;
			end
			idx_s5 <= idx_s4;

			// stage 6: combine partials
			for (int i = 0; i < 3; i++) begin
				csq_s6[i] <= (litp_pkg::CSQ_W'(hh_s5[i]) << (2 * C))
					+ (litp_pkg::CSQ_W'(hl_s5[i]) << (C + 1))
					+ litp_pkg::CSQ_W'(ll_s5[i]);
				mag_s6[i] <= (litp_pkg::MAGN_W'(dth_s5[i]) << litp_pkg::TLO_W)
					+ litp_pkg::MAGN_W'(dtl_s5[i]);
				nneg_s6[i] <= nneg_s5[i];
			end
			idx_s6 <= idx_s5;

			// stage 7: |c|^2 and the rounding numerators
			cc_s7 <= litp_pkg::CC_W'(csq_s6[0]) + litp_pkg::CC_W'(csq_s6[1])
				+ litp_pkg::CC_W'(csq_s6[2]);
			for (int i = 0; i < 3; i++) begin
				rem_sd[0][i] <= (NW'(mag_s6[i]) << 1) + NW'(dd3_q);
				quo_sd[0][i] <= '0;
				neg_sd[0][i] <= nneg_s6[i];
			end
			idx_sd[0] <= idx_s6;

			// divider stages; the inlier compare rides along
			inl_sd[1] <= cc_s7 < litp_pkg::CC_W'(lim2dd5_q);
			for (int j = 2; j <= QW; j++) inl_sd[j] <= inl_sd[j-1];
			for (int j = 1; j <= QW; j++) begin
				for (int i = 0; i < 3; i++) begin
					rem_sd[j][i] <= rem_nx[j][i];
					quo_sd[j][i] <= quo_nx[j][i];
					neg_sd[j][i] <= neg_sd[j-1][i];
				end
				idx_sd[j] <= idx_sd[j-1];
			end

			word_sf <= res_nx;
		end
	end

`ifndef NO_ASSERTIONS
	// a held skid word is always presented
	a_skid_shown: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_valid && (res_word == skid_q))
		else $error("skid word not presented");

	// a refused skid word stays put
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !res_ready |=> skid_v_q && $stable(skid_q))
		else $error("skid word lost under stall");

	// a degenerate line never reports an inlier
	a_degen_no_inlier: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.line_degenerate |-> !res_word.is_inlier)
		else $error("inlier on degenerate line");

	// an advance without an input word leaves a bubble in stage 1
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		en && !pt_valid |=> !v_s1)
		else $error("stage 1 valid without input");
`endif

endmodule

`default_nettype wire

// File: tb/sv/line_inlier_test_and_projection_tb.sv
// Testbench for line_inlier_test_and_projection: random and directed points
// against a wide-integer predictor of the inlier test and line projection.
// Depends on litp_pkg and the block's top level.
`timescale 1ns / 1ps

module line_inlier_test_and_projection_tb;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [litp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [litp_pkg::COORD_W-1:0] cfg_wdata;
	logic pt_valid;
	logic pt_ready;
	litp_pkg::point_t pt_word;
	logic res_valid;
	logic res_ready;
	litp_pkg::result_t res_word;

	line_inlier_test_and_projection dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.pt_valid(pt_valid), .pt_ready(pt_ready), .pt_word(pt_word),
		.res_valid(res_valid), .res_ready(res_ready), .res_word(res_word)
	);

	// predictor copy of the line registers
	logic signed [litp_pkg::COORD_W-1:0] line_a [3];
	logic signed [litp_pkg::COORD_W-1:0] line_b [3];
	logic [litp_pkg::LIMIT_W-1:0] limit_q;

	litp_pkg::point_t pending_points [$];
	litp_pkg::result_t expected_results [$];
	int error_count;
	bit stim_done;
	bit hold_sender;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

	// round half away from zero of num/den for den > 0; wide signed math
	function automatic litp_pkg::result_t predict_result(litp_pkg::point_t p);
		logic signed [255:0] d [3];
		logic signed [255:0] w [3];
		logic signed [255:0] dd, cx, cy, cz, cc, lim2dd, dot, num, mag, q, v, hi, lo;
		litp_pkg::result_t r;
		d[0] = line_b[0] - line_a[0];
		d[1] = line_b[1] - line_a[1];
		d[2] = line_b[2] - line_a[2];
		w[0] = p.point_x - line_a[0];
		w[1] = p.point_y - line_a[1];
		w[2] = p.point_z - line_a[2];
		dd = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
		r.index_out = p.point_index;
		r.line_degenerate = (dd == 0);
		r.is_inlier = 1'b0;
		r.proj_x = line_a[0];
		r.proj_y = line_a[1];
		r.proj_z = line_a[2];
		if (dd != 0) begin
			cx = w[1]*d[2] - w[2]*d[1];
			cy = w[2]*d[0] - w[0]*d[2];
			cz = w[0]*d[1] - w[1]*d[0];
			cc = cx*cx + cy*cy + cz*cz;
			lim2dd = $signed({225'd0, limit_q}) * $signed({225'd0, limit_q}) * dd;
			r.is_inlier = (cc < lim2dd);
			dot = w[0]*d[0] + w[1]*d[1] + w[2]*d[2];
			hi = 256'sd2147483647;
			lo = -256'sd2147483648;
			for (int i = 0; i < 3; i++) begin
				num = d[i] * dot;
				mag = (num < 0) ? -num : num;
				q = (2*mag + dd) / (2*dd);
				if (num < 0) q = -q;
				v = line_a[i] + q;
				if (v > hi) v = hi;
				if (v < lo) v = lo;
				if (i == 0) r.proj_x = v[litp_pkg::COORD_W-1:0];
				else if (i == 1) r.proj_y = v[litp_pkg::COORD_W-1:0];
				else r.proj_z = v[litp_pkg::COORD_W-1:0];
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	// append one point to the send list
	function automatic void queue_point(litp_pkg::point_t p);
		pending_points.insert(pending_points.size(), p);
	endfunction

	// driver: hold each word until accepted, random gap between words
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
			pt_word <= '0;
			gap_left <= 0;
		end else begin
			logic take;
			take = pt_valid && pt_ready;
			if (take) expected_results.insert(expected_results.size(), predict_result(pt_word));
			if (pt_valid && !take) begin
				// hold
			end else if (gap_left > 0) begin
				pt_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_points.size() > 0 && !hold_sender) begin
				pt_valid <= 1'b1;
				pt_word <= pending_points.pop_front();
				gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
			end else begin
				pt_valid <= 1'b0;
			end
		end
	end

	// monitor: random receiver stalls, compare each word with oldest expectation
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word", 64'(res_word.index_out), 64'(0));
				end else begin
					litp_pkg::result_t e;
					e = expected_results.pop_front();
					if (res_word.is_inlier !== e.is_inlier)
						report_mismatch("is_inlier", 64'(res_word.is_inlier),
							64'(e.is_inlier));
					if (res_word.index_out !== e.index_out)
						report_mismatch("index_out", 64'(res_word.index_out),
							64'(e.index_out));
					if (res_word.proj_x !== e.proj_x)
						report_mismatch("proj_x", 64'(res_word.proj_x), 64'(e.proj_x));
					if (res_word.proj_y !== e.proj_y)
						report_mismatch("proj_y", 64'(res_word.proj_y), 64'(e.proj_y));
					if (res_word.proj_z !== e.proj_z)
						report_mismatch("proj_z", 64'(res_word.proj_z), 64'(e.proj_z));
					if (res_word.line_degenerate !== e.line_degenerate)
						report_mismatch("line_degenerate", 64'(res_word.line_degenerate),
							64'(e.line_degenerate));
				end
			end
			if (stall_left > 0) begin
				res_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				res_ready <= 1'b1;
				if (res_valid && res_ready && $urandom_range(0, 3) == 0)
					stall_left <= $urandom_range(0, 14);
			end
		end
	end

	// write one register into the block and the predictor
	task automatic write_reg(litp_pkg::cfg_reg_t idx, logic [litp_pkg::COORD_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			litp_pkg::CFG_A_X: line_a[0] = val;
			litp_pkg::CFG_A_Y: line_a[1] = val;
			litp_pkg::CFG_A_Z: line_a[2] = val;
			litp_pkg::CFG_B_X: line_b[0] = val;
			litp_pkg::CFG_B_Y: line_b[1] = val;
			litp_pkg::CFG_B_Z: line_b[2] = val;
			litp_pkg::CFG_LIMIT: limit_q = val[litp_pkg::LIMIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_line(logic [litp_pkg::COORD_W-1:0] ax, ay, az, bx, by, bz,
		logic [litp_pkg::COORD_W-1:0] lim);
		write_reg(litp_pkg::CFG_A_X, ax);
		write_reg(litp_pkg::CFG_A_Y, ay);
		write_reg(litp_pkg::CFG_A_Z, az);
		write_reg(litp_pkg::CFG_B_X, bx);
		write_reg(litp_pkg::CFG_B_Y, by);
		write_reg(litp_pkg::CFG_B_Z, bz);
		write_reg(litp_pkg::CFG_LIMIT, lim);
	endtask

	// wait until the pipe drains completely; sample away from the active edge
	task automatic drain();
		@(negedge clk);
		while (pending_points.size() > 0 || pt_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [litp_pkg::COORD_W-1:0] rand_coord(int scale);
		case (scale)
			0: return $urandom;
			1: return $signed($urandom_range(0, 'h7FFFF)) - 'sh40000;
			default: return $signed($urandom_range(0, 'h7FFFFF)) - 'sh400000;
		endcase
	endfunction

	function automatic litp_pkg::point_t make_point(logic [litp_pkg::COORD_W-1:0] x, y, z);
		litp_pkg::point_t p;
		p.point_x = x;
		p.point_y = y;
		p.point_z = z;
		p.point_index = litp_pkg::INDEX_W'($urandom);
		return p;
	endfunction

	initial begin
		int scale;
		logic [litp_pkg::COORD_W-1:0] ax, ay, az;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n = 0;
		hold_sender = 0;
		error_count = 0;
		for (int i = 0; i < 3; i++) begin
			line_a[i] = 0;
			line_b[i] = 0;
		end
		limit_q = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// degenerate line straight out of reset
		queue_point(make_point(32'h7FFFFFFF, 32'h80000000, 0));
		queue_point(make_point(32'h12345678, 32'hFFFFFFFF, 32'h1));
		drain();

		// extremes: full-range line, maximum limit, corner points
		set_line(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		queue_point(make_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
		queue_point(make_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
		queue_point(make_point(0, 0, 0));
		queue_point(make_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
		begin
			litp_pkg::point_t p;
			p = make_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
			p.point_index = '1;
			queue_point(p);
			p.point_index = '0;
			queue_point(p);
		end
		drain();

		// zero limit; points at A and far beyond both ends of the line
		set_line(0, 0, 0, 32'h00010000, 0, 0, 0);
		queue_point(make_point(0, 0, 0));
		queue_point(make_point(32'h7FFFFFFF, 5, 5));
		queue_point(make_point(32'h80000000, 0, 0));
		drain();

		// rounding halves on a short line with a small limit
		set_line(0, 0, 0, 2, 0, 0, 32'h00010000);
		queue_point(make_point(1, 0, 0));
		queue_point(make_point(32'hFFFFFFFF, 0, 0));
		drain();
		set_line(0, 0, 0, 2, 2, 0, 3);
		queue_point(make_point(1, 0, 0));
		queue_point(make_point(32'hFFFFFFFF, 0, 0));
		queue_point(make_point(1, 1, 1));
		drain();

		// random phases: new line each phase, points clustered near it
		for (int ph = 0; ph < 30; ph++) begin
			scale = $urandom_range(0, 2);
			ax = rand_coord(scale);
			ay = rand_coord(scale);
			az = rand_coord(scale);
			if (ph % 10 == 9)
				set_line(ax, ay, az, ax, ay, az, $urandom);
			else
				set_line(ax, ay, az, rand_coord(scale), rand_coord(scale),
					rand_coord(scale),
					(ph % 7 == 3) ? 0 : $urandom_range(0, 2) == 0 ? $urandom :
					$urandom_range(0, 'h3FFFF));
			for (int n = 0; n < 60; n++) begin
				int step;
				if ($urandom_range(0, 3) == 0) begin
					queue_point(make_point(rand_coord(scale),
						rand_coord(scale), rand_coord(scale)));
				end else begin
					// point near A + s(B - A), small random offset
					step = int'($urandom_range(0, 4));
					queue_point(make_point(
						line_a[0] + (line_b[0] - line_a[0]) * step / 2
							+ $signed(rand_coord(1)) / 64,
						line_a[1] + (line_b[1] - line_a[1]) * step / 2
							+ $signed(rand_coord(1)) / 64,
						line_a[2] + (line_b[2] - line_a[2]) * step / 2
							+ $signed(rand_coord(1)) / 64));
				end
				if (ph == 5 && n == 30) begin
					// send the first part, then hold the sender until all of it is back
					@(negedge clk);
					while (pending_points.size() > 0) @(negedge clk);
					hold_sender = 1;
					while (pt_valid || expected_results.size() > 0) @(negedge clk);
					hold_sender = 0;
				end
			end
			drain();
		end

		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: line_inlier_test_and_projection.f
sv/litp_pkg.sv
sv/line_inlier_test_and_projection.sv
tb/sv/line_inlier_test_and_projection_tb.sv
